// ===== hdl/crast_pkg.sv =====
// Shared types and constants for the circle rasterizer.
package crast_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 11;
  localparam int OUT_BITS    = COORD_BITS + 2;
  localparam int OFFX_BITS   = COORD_BITS;
  localparam int OFFY_BITS   = RADIUS_BITS + 2;
  localparam int DEC_BITS    = RADIUS_BITS + 3;
  localparam int CALC_BITS   = OUT_BITS + 2;
  localparam int PHASE_BITS  = 3;

  localparam int IN_FIELD_BITS = 2 * COORD_BITS + RADIUS_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 3 * OUT_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  localparam logic [PHASE_BITS-1:0] PHASE_FINAL = 3'd7;
  localparam logic [1:0]            SPAN_FINAL  = 2'd3;

  typedef struct packed {
    logic                   req_type;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius;
  } crast_req_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] pos_x;
    logic signed [OUT_BITS-1:0] pos_y;
    logic signed [OUT_BITS-1:0] end_x;
    logic                       last;
  } crast_res_t;

endpackage

// ===== hdl/crast_in_stage.sv =====
// Input register: holds one accepted request beat until the core takes it.
module crast_in_stage
  import crast_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_DATA_BITS-1:0] in_tdata,
  input  logic                    in_tuser,
  input  logic                    take,
  output logic                    req_vld,
  output crast_req_t              req
);

  logic       vld_r, vld_nxt;
  crast_req_t req_r;
  logic       load;

  assign in_tready = !vld_r || take;
  assign load      = in_tvalid && in_tready;
  assign vld_nxt   = load ? 1'b1 : (take ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_r.req_type <= in_tuser;
      req_r.center_x <= in_tdata[COORD_BITS-1:0];
      req_r.center_y <= in_tdata[2*COORD_BITS-1:COORD_BITS];
      req_r.radius   <= in_tdata[IN_FIELD_BITS-1:2*COORD_BITS];
    end
  end

  assign req_vld = vld_r;
  assign req     = req_r;

endmodule

// ===== hdl/crast_core.sv =====
// Midpoint circle state, primitive selection and iteration update.
module crast_core
  import crast_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fill_mode,
  input  logic       fire,
  input  crast_req_t req,
  output logic       emit,
  output crast_res_t res
);

  logic        [OFFX_BITS-1:0]   off_x_r, off_x_nxt;
  logic signed [OFFY_BITS-1:0]   off_y_r, off_y_nxt;
  logic signed [DEC_BITS-1:0]    dec_r, dec_nxt;
  logic        [PHASE_BITS-1:0]  phase_r, phase_nxt;
  logic        [COORD_BITS-1:0]  cx_r, cx_nxt;
  logic        [COORD_BITS-1:0]  cy_r, cy_nxt;
  logic        [RADIUS_BITS-1:0] rad_r, rad_nxt;
  logic                          busy_r, busy_nxt;

  logic signed [CALC_BITS-1:0] cx, cy, ox, oy, rd, d;
  logic signed [CALC_BITS-1:0] px, py, ex;
  logic signed [CALC_BITS-1:0] d_upd, ox_upd, oy_upd;
  logic                        end_iter, last;

  assign cx = CALC_BITS'(signed'({1'b0, cx_r}));
  assign cy = CALC_BITS'(signed'({1'b0, cy_r}));
  assign ox = CALC_BITS'(signed'({1'b0, off_x_r}));
  assign oy = CALC_BITS'(off_y_r);
  assign rd = CALC_BITS'(signed'({1'b0, rad_r}));
  assign d  = CALC_BITS'(dec_r);

  assign emit = (req.req_type == REQ_ADVANCE) && busy_r;

  always_comb begin
    if (fill_mode) begin
      case (phase_r[1:0])
        2'd0: begin px = cx - oy; ex = cx + oy; py = cy + ox; end
        2'd1: begin px = cx - ox; ex = cx + ox; py = cy + oy; end
        2'd2: begin px = cx - ox; ex = cx + ox; py = cy - oy; end
        default: begin px = cx - oy; ex = cx + oy; py = cy - ox; end
      endcase
      end_iter = (phase_r[1:0] == SPAN_FINAL) || (phase_r == PHASE_FINAL);
    end else begin
      case (phase_r)
        3'd0: begin px = cx + ox; py = cy + oy; end
        3'd1: begin px = cx + oy; py = cy + ox; end
        3'd2: begin px = cx - ox; py = cy + oy; end
        3'd3: begin px = cx - oy; py = cy + ox; end
        3'd4: begin px = cx + ox; py = cy - oy; end
        3'd5: begin px = cx + oy; py = cy - ox; end
        3'd6: begin px = cx - ox; py = cy - oy; end
        default: begin px = cx - oy; py = cy - ox; end
      endcase
      ex = px;
      end_iter = (phase_r == PHASE_FINAL);
    end
  end

  always_comb begin
    if (d >= (ox <<< 1)) begin
      d_upd  = d - (ox <<< 1) - CALC_BITS'(1);
      ox_upd = ox + CALC_BITS'(1);
      oy_upd = oy;
    end else if (d < ((rd - oy) <<< 1)) begin
      d_upd  = d + (oy <<< 1) - CALC_BITS'(1);
      ox_upd = ox;
      oy_upd = oy - CALC_BITS'(1);
    end else begin
      d_upd  = d + ((oy - ox - CALC_BITS'(1)) <<< 1);
      ox_upd = ox + CALC_BITS'(1);
      oy_upd = oy - CALC_BITS'(1);
    end
  end

  assign last = end_iter && (oy_upd < ox_upd);

  assign res.pos_x = px[OUT_BITS-1:0];
  assign res.pos_y = py[OUT_BITS-1:0];
  assign res.end_x = ex[OUT_BITS-1:0];
  assign res.last  = last;

  always_comb begin
    off_x_nxt = off_x_r;
    off_y_nxt = off_y_r;
    dec_nxt   = dec_r;
    phase_nxt = phase_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    rad_nxt   = rad_r;
    busy_nxt  = busy_r;
    if (fire) begin
      if (req.req_type == REQ_START) begin
        cx_nxt    = req.center_x;
        cy_nxt    = req.center_y;
        rad_nxt   = req.radius;
        off_x_nxt = '0;
        off_y_nxt = OFFY_BITS'(signed'({1'b0, req.radius}));
        dec_nxt   = DEC_BITS'(signed'({1'b0, req.radius})) - DEC_BITS'(1);
        phase_nxt = '0;
        busy_nxt  = 1'b1;
      end else if (busy_r) begin
        if (end_iter) begin
          off_x_nxt = ox_upd[OFFX_BITS-1:0];
          off_y_nxt = oy_upd[OFFY_BITS-1:0];
          dec_nxt   = d_upd[DEC_BITS-1:0];
          phase_nxt = '0;
          busy_nxt  = !last;
        end else begin
          phase_nxt = phase_r + PHASE_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      dec_r   <= '0;
      phase_r <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
      rad_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      off_x_r <= off_x_nxt;
      off_y_r <= off_y_nxt;
      dec_r   <= dec_nxt;
      phase_r <= phase_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      rad_r   <= rad_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

// ===== hdl/crast_out_stage.sv =====
// Result register: holds one primitive beat until the sink takes it.
module crast_out_stage
  import crast_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic                     load_vld,
  input  crast_res_t               res,
  output logic                     free,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic                     out_tlast
);

  logic       vld_r, vld_nxt;
  crast_res_t res_r;

  assign free    = !vld_r || out_tready;
  assign vld_nxt = load ? load_vld : (out_tready ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_vld) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {(OUT_DATA_BITS - OUT_FIELD_BITS)'(0),
                       res_r.end_x, res_r.pos_y, res_r.pos_x};
  assign out_tlast  = res_r.last;

endmodule

// ===== hdl/circle_rasterizer_unit.sv =====
// Circle rasterizer top level: request and result streams, mode register.
//
// Midpoint circle rasterizer. A request beat with tuser low starts a circle
// from its center and radius and yields no result; a beat with tuser high
// advances the circle by one primitive (an outline point, or a horizontal
// span when fill_mode is set) and yields one result beat, or nothing when no
// circle is in progress. The final primitive carries tlast. Every request
// passes an input register and the selection and decision update logic into
// a result register, so one request is taken per clock while the result
// register is free; a request waits in the input register until then, and
// its result is registered as the core takes it. The only stall comes from
// the result register while the sink holds out_tready low. fill_mode may
// change part way through a circle and takes effect from the next primitive;
// write it only while no beat is in flight.
module circle_rasterizer_unit
  import crast_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata,      // fill_mode
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,       // center_x, center_y, radius
  input  logic                     in_tuser,       // req_type
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,      // pos_x, pos_y, end_x
  output logic                     out_tlast
);

  logic       fill_mode_r;
  logic       req_vld;
  crast_req_t req;
  logic       out_free;
  logic       fire;
  logic       emit;
  crast_res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_mode_r <= 1'b0;
    end else if (cfg_we) begin
      fill_mode_r <= cfg_wdata;
    end
  end

  assign fire = req_vld && out_free;

  crast_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take      (fire),
    .req_vld   (req_vld),
    .req       (req)
  );

  crast_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fill_mode (fill_mode_r),
    .fire      (fire),
    .req       (req),
    .emit      (emit),
    .res       (res)
  );

  crast_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .load_vld   (emit),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
